FILE: hdl/fbe_pkg.sv
// Shared constants, register codes and arithmetic helpers for the feedback echo block.
package fbe_pkg;

  localparam int DELAY_DEPTH = 32768;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 12;
  localparam int FRAC_W      = 12;
  localparam int SUM_W       = 30;
  localparam int QUOT_W      = SUM_W - FRAC_W;
  localparam int CFG_INDEX_W = 8;

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DELAY_DEPTH - 1);
  localparam logic [FRAC_W:0]   GAIN_ONE  = (FRAC_W+1)'(1 << FRAC_W);

  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MIX           = CFG_INDEX_W'(1);

  // Divide by 2^FRAC_W, rounding toward zero.
  function automatic logic signed [QUOT_W-1:0] div_trunc(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W-1:0] biased;
    biased = sum[SUM_W-1] ? sum + SUM_W'((1 << FRAC_W) - 1) : sum;
    return QUOT_W'(biased >>> FRAC_W);
  endfunction

  // Clamp to the signed 16-bit sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [QUOT_W-1:0] v);
    logic signed [QUOT_W-1:0] hi;
    logic signed [QUOT_W-1:0] lo;
    hi = QUOT_W'(32767);
    lo = -QUOT_W'(32768);
    if (v > hi) begin
      return 16'sh7FFF;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: hdl/feedback_echo_with_wet_dry_mix.sv
// Feedback echo with dry/wet mix: delay memory, three-stage datapath and stream ports.
//
// One stereo frame is taken per transfer on the s_ side and one frame comes out per
// transfer on the m_ side, one frame per clock sustained while m_tready stays high.
// m_tvalid is registered through v1 and v2. The rate is set by the delay memory: every
// frame does one read of the slot at the write pointer (issued in the transfer cycle,
// data in the next cycle) and one write of the new feedback value into that slot as
// the frame moves from stage 2 into the output register, on separate read and write
// ports. The right sample is passed through unchanged. The left output is the crossfade
// trunc((left*(4096-mix) + delayed*mix)/4096) saturated to 16 bits, and the slot
// receives trunc((left*4096 + delayed*feedback_gain)/4096) saturated. The memory needs
// no clearing pass after reset: the pointer fills it in order, so until it first wraps
// every slot it reads was never written and is replaced by zero. The whole datapath
// advances only when the output register is empty or being taken, so s_tready
// is !m_tvalid || m_tready. Write feedback_gain (index 0) and mix (index 1) through the
// cfg_ channel only while no frame is in flight; cfg_ready is always high.
module feedback_echo_with_wet_dry_mix
  import fbe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // config write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]      cfg_data,
  // input frames
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // [15:0] left_in, [31:16] right_in
  // output frames
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata    // [15:0] left_out, [31:16] right_out
);

  logic [GAIN_W-1:0] feedback_gain;
  logic [GAIN_W-1:0] mix;

  logic              adv;
  logic              in_xfer;

  logic [ADDR_W-1:0] ptr;
  logic              wrapped;

  logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];
  logic [SAMPLE_W-1:0] rd_data;

  // stage 1: memory read in flight
  logic                       v1;
  logic                       zero1;
  logic signed [SAMPLE_W-1:0] left1;
  logic [SAMPLE_W-1:0]        right1;
  logic [ADDR_W-1:0]          addr1;
  logic signed [SAMPLE_W-1:0] delayed1;
  logic [FRAC_W:0]            mix_inv;

  // stage 2: products
  logic                       v2;
  logic signed [SAMPLE_W-1:0] left2;
  logic [SAMPLE_W-1:0]        right2;
  logic [ADDR_W-1:0]          addr2;
  logic signed [SUM_W-1:0]    prod_fb2;
  logic signed [SUM_W-1:0]    prod_dry2;
  logic signed [SUM_W-1:0]    prod_wet2;

  // stage 3: sums, rounding and saturation
  logic signed [SUM_W-1:0]    fb_sum;
  logic signed [SUM_W-1:0]    wet_sum;
  logic signed [SAMPLE_W-1:0] fb_sat;
  logic signed [SAMPLE_W-1:0] wet_sat;
  logic                       wr_en;

  assign cfg_ready = 1'b1;
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign in_xfer   = s_tvalid && s_tready;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_gain <= '0;
      mix           <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
        REG_MIX:           mix           <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Write pointer and first-wrap flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      wrapped <= 1'b0;
    end else if (in_xfer) begin
      if (ptr == ADDR_LAST) begin
        ptr     <= '0;
        wrapped <= 1'b1;
      end else begin
        ptr <= ptr + ADDR_W'(1);
      end
    end
  end

  // Delay memory: read at the pointer on each transfer, write back from stage 3.
  // A slot is read again only DELAY_DEPTH frames later, long after its write lands.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr2] <= fb_sat;
    end
    if (in_xfer) begin
      rd_data <= mem[ptr];
    end
  end

  // Stage 1 capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      left1  <= s_tdata[15:0];
      right1 <= s_tdata[31:16];
      addr1  <= ptr;
      zero1  <= !wrapped;
    end
  end

  assign delayed1 = zero1 ? '0 : rd_data;
  assign mix_inv  = GAIN_ONE - {1'b0, mix};

  // Stage 2: one multiply per path, registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      left2     <= left1;
      right2    <= right1;
      addr2     <= addr1;
      prod_fb2  <= SUM_W'(delayed1) * $signed({{(SUM_W-GAIN_W){1'b0}}, feedback_gain});
      prod_dry2 <= SUM_W'(left1) * $signed({{(SUM_W-FRAC_W-1){1'b0}}, mix_inv});
      prod_wet2 <= SUM_W'(delayed1) * $signed({{(SUM_W-GAIN_W){1'b0}}, mix});
    end
  end

  // Stage 3: sum, round toward zero, clamp.
  assign fb_sum  = $signed({{(SUM_W-SAMPLE_W-FRAC_W){left2[SAMPLE_W-1]}}, left2,
                            {FRAC_W{1'b0}}}) + prod_fb2;
  assign wet_sum = prod_dry2 + prod_wet2;
  assign fb_sat  = sat16(div_trunc(fb_sum));
  assign wet_sat = sat16(div_trunc(wet_sum));
  assign wr_en   = adv && v2;

  // Output register: hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      m_tdata <= {right2, wet_sat};
    end
  end

  // Pointer steps by one per input transfer, wrapping at the last slot.
  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (ptr == (($past(ptr) == ADDR_LAST) ? '0 : $past(ptr) + ADDR_W'(1))))
    else $error("write pointer did not advance by one slot");

  // Once the memory has been filled the zero override stays off.
  a_wrap_sticky: assert property (@(posedge clk) disable iff (rst) !$fell(wrapped))
    else $error("wrap flag dropped outside reset");

  // The slot written back from stage 3 is the one read when the frame was taken in.
  a_wr_addr: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && adv) ##1 adv ##1 adv |-> (addr2 == $past(ptr, 2)) && wr_en)
    else $error("write-back address does not match read address");

  // Nothing comes out of an empty pipeline after reset.
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid && !v1 && !v2)
    else $error("pipeline valid set right after reset");

endmodule
